// ===== rtl/sha1_byte_stream_hasher_assert.svh =====
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_assert.svh
// assertion macros for the sha-1 stream hasher, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SBH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define SBH_ASSERT_NOW(label, ante, cons, msg)
`define SBH_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/sha1bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// types, constants and sequencer states shared by the sha-1 stream hasher
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

    // operation codes of an input transaction
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // initial chaining vector
    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hEFCD_AB89;
    localparam logic [31:0] IV2 = 32'h98BA_DCFE;
    localparam logic [31:0] IV3 = 32'h1032_5476;
    localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

    // round constants
    localparam logic [31:0] K0 = 32'h5A82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hCA62_C1D6;

    // padding
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_h0;
        logic [31:0] digest_h1;
        logic [31:0] digest_h2;
        logic [31:0] digest_h3;
        logic [31:0] digest_h4;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic       load_byte;
        logic       round_en;
        logic       init_work;
        logic       fold;
        logic       reset_chain;
        logic [6:0] round_idx;
    } ctl_t;

endpackage

// ===== rtl/sha1bsh_window.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_window
// 64-byte block buffer that doubles as the 16-word message schedule window
// ----------------------------------------------------------------------------
module sha1bsh_window (
    input  logic              aclk,
    input  sha1bsh_pkg::ctl_t ctl,
    input  logic [7:0]        byte_in,
    output logic [31:0]       w_out
);
    import sha1bsh_pkg::*;

    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  mix;
    logic [31:0]  w_new;

    // schedule recurrence on the window taps w[i+13], w[i+8], w[i+2], w[i]
    assign mix   = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ win_reg[511:480];
    assign w_new = {mix[30:0], mix[31]};
    assign w_out = win_reg[511:480];

    // bytes shift in at the bottom, schedule words shift out at the top
    always_comb begin
        win_next = win_reg;
        if (ctl.load_byte) begin
            win_next = {win_reg[503:0], byte_in};
        end else if (ctl.round_en) begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

// ===== rtl/sha1bsh_round.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_round
// shared single-round compression unit with working and chaining registers
// ----------------------------------------------------------------------------
module sha1bsh_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha1bsh_pkg::ctl_t ctl,
    input  logic [31:0]       w_in,
    output sha1bsh_pkg::out_t chain
);
    import sha1bsh_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    // round function and constant by round group
    always_comb begin
        if (ctl.round_idx inside {[7'd0:7'd19]}) begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K0;
        end else if (ctl.round_idx inside {[7'd20:7'd39]}) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (ctl.round_idx inside {[7'd40:7'd59]}) begin
            f_val = (b_reg & (c_reg | d_reg)) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_in;

    // working variables
    always_ff @(posedge aclk) begin
        if (ctl.init_work) begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
            e_reg <= h4_reg;
        end else if (ctl.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.reset_chain) begin
            h0_reg <= IV0;
            h1_reg <= IV1;
            h2_reg <= IV2;
            h3_reg <= IV3;
            h4_reg <= IV4;
        end else if (ctl.fold) begin
            h0_reg <= h0_reg + a_reg;
            h1_reg <= h1_reg + b_reg;
            h2_reg <= h2_reg + c_reg;
            h3_reg <= h3_reg + d_reg;
            h4_reg <= h4_reg + e_reg;
        end
    end

    assign chain.digest_h0 = h0_reg;
    assign chain.digest_h1 = h1_reg;
    assign chain.digest_h2 = h2_reg;
    assign chain.digest_h3 = h3_reg;
    assign chain.digest_h4 = h4_reg;

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// streaming sha-1: absorbs one message byte per transaction, finishes on
// request and returns the five digest words
// ----------------------------------------------------------------------------
// The transaction carrying the 64th byte of a block keeps the hasher busy
// for 80 rounds through the single shared round unit and then the chaining
// fold, so no bytes are taken while a block compresses. A finish
// transaction pushes the padding and length one byte per cycle, runs one or
// two more compressions and hands over the digest. The digest sits in an
// output register, so new bytes are taken while it waits; a second digest
// keeps the hasher busy until the first is taken.
`include "sha1_byte_stream_hasher_assert.svh"

module sha1_byte_stream_hasher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sha1bsh_pkg::in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sha1bsh_pkg::out_t m_data
);
    import sha1bsh_pkg::*;

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  len_reg, len_next;
    logic [63:0]  pad_len_reg, pad_len_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_phase_reg, len_phase_next;
    logic         fin_reg, fin_next;
    logic [6:0]   round_reg, round_next;
    logic         m_valid_reg, m_valid_next;
    out_t         m_data_reg, m_data_next;
    logic [7:0]   byte_sel;
    logic         in_fire;
    logic         len_byte;
    ctl_t         ctl;
    out_t         chain;
    logic [31:0]  w_word;

    assign in_fire  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // padding byte: marker, then zeros, then the big-endian bit length
    assign len_byte = len_phase_reg || (!pad_first_reg && fill_reg == LEN_OFFSET);
    always_comb begin
        if (state_reg == ST_IDLE) begin
            byte_sel = s_data.data_byte;
        end else if (pad_first_reg) begin
            byte_sel = PAD_MARK;
        end else if (len_byte) begin
            byte_sel = pad_len_reg[63:56];
        end else begin
            byte_sel = 8'h00;
        end
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            fin_reg       <= 1'b0;
            round_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            fin_reg       <= fin_next;
            round_reg     <= round_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_len_reg <= pad_len_next;
        m_data_reg  <= m_data_next;
    end

    // next state and datapath commands
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        pad_len_next    = pad_len_reg;
        pad_first_next  = pad_first_reg;
        len_phase_next  = len_phase_reg;
        fin_next        = fin_reg;
        round_next      = round_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ctl             = '0;
        ctl.round_idx   = round_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.op == OP_ABSORB) begin
                        ctl.load_byte = 1'b1;
                        fill_next     = fill_reg + 6'd1;
                        len_next      = len_reg + 61'd1;
                        fin_next      = 1'b0;
                        if (fill_reg == LAST_BYTE) begin
                            ctl.init_work = 1'b1;
                            state_next    = ST_ROUND;
                        end
                    end else begin
                        pad_len_next   = {len_reg, 3'b000};
                        len_next       = '0;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        fin_next       = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.load_byte  = 1'b1;
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                if (len_byte) begin
                    len_phase_next = 1'b1;
                    pad_len_next   = {pad_len_reg[55:0], 8'h00};
                end
                if (fill_reg == LAST_BYTE) begin
                    ctl.init_work = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.round_en = 1'b1;
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (len_phase_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = chain;
                    ctl.reset_chain = 1'b1;
                    fin_next        = 1'b0;
                    len_phase_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sha1bsh_window u_window (
        .aclk    (aclk),
        .ctl     (ctl),
        .byte_in (byte_sel),
        .w_out   (w_word)
    );

    sha1bsh_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .w_in    (w_word),
        .chain   (chain)
    );

    // compression only ever starts on a freshly filled block
    `SBH_ASSERT_NOW(a_round_on_full_block, $rose(state_reg == ST_ROUND), fill_reg == 6'd0, "compression started with a partial block")
    // the last round is always followed by the chaining fold
    `SBH_ASSERT_NEXT(a_fold_after_last_round, state_reg == ST_ROUND && round_reg == LAST_ROUND, state_reg == ST_FOLD, "missing fold after last round")
    // a new digest leaves the hasher with an empty buffer and zero length
    `SBH_ASSERT_NOW(a_clean_after_digest, $rose(m_valid), fill_reg == 6'd0 && len_reg == 61'd0, "stale message state after digest")

endmodule
